// File: src/human_size_parser_core_defines.svh
// Assertion macros used by the size parser RTL.
`ifndef HUMAN_SIZE_PARSER_CORE_DEFINES_SVH
`define HUMAN_SIZE_PARSER_CORE_DEFINES_SVH

// Checks a property on every rising edge while reset is released.
`define HSP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("size parser check failed");

// Checks that a condition in one cycle brings another in the next cycle.
`define HSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("size parser sequence check failed");

`endif

// File: src/hsp_pkg.sv
`default_nettype none

package hsp_pkg;

  // Number of fraction digits that are kept; later ones are dropped.
  localparam int unsigned FRAC_DIGITS = 9;

  // Power of ten, for elaboration-time constants.
  function automatic longint unsigned pow10(int unsigned n);
    longint unsigned p;
    p = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  localparam longint unsigned FracMax = pow10(FRAC_DIGITS);
  localparam int unsigned FracW = $clog2(FracMax + 64'd1);
  localparam int unsigned CntW = $clog2(FRAC_DIGITS + 1);
  localparam int unsigned ShiftW = 6;

  // Character codes used by the lexer.
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChSpace = 8'h20;

  // Signed 64-bit limits for positive and negative magnitudes.
  localparam logic [63:0] LimPos = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] LimNeg = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_SPACE,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_DIV,
    SC_SCALE,
    SC_SUM,
    SC_FINISH
  } scale_e;

  // Parsed key, handed from the lexer to the scaler.
  typedef struct packed {
    logic              neg;
    logic [63:0]       acc;
    logic [FracW-1:0]  frac;
    logic [CntW-1:0]   cnt;
    logic [ShiftW-1:0] shift;
    logic              ovf;
  } lex_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c inside {[8'h09:8'h0d], ChSpace});
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  // Binary suffix to shift amount; unknown bytes give no shift.
  function automatic logic [ShiftW-1:0] suffix_of(logic [7:0] c);
    logic [ShiftW-1:0] s;
    case (c)
      "k", "K": s = ShiftW'(10);
      "m", "M": s = ShiftW'(20);
      "g", "G": s = ShiftW'(30);
      "t", "T": s = ShiftW'(40);
      "P":      s = ShiftW'(50);
      "E":      s = ShiftW'(60);
      default:  s = '0;
    endcase
    return s;
  endfunction

  // Divisor 10^n for a fraction of n digits, as a constant table.
  function automatic logic [FracW-1:0] den_of(logic [CntW-1:0] n);
    logic [FracW-1:0] r;
    r = '0;
    for (int unsigned i = 0; i <= FRAC_DIGITS; i++) begin
      if (n == CntW'(i)) begin
        r = FracW'(pow10(i));
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/hsp_if.sv
`default_nettype none

// Byte channel into the parser.
interface hsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_char;
  logic       last_char;

  modport source(output valid, char_byte, has_char, last_char, input ready);
  modport sink(input valid, char_byte, has_char, last_char, output ready);
endinterface

// Result channel out of the parser.
interface hsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] size_value;
  logic               saturated;

  modport source(output valid, size_value, saturated, input ready);
  modport sink(input valid, size_value, saturated, output ready);
endinterface

`default_nettype wire

// File: src/hsp_lex.sv
`default_nettype none

module hsp_lex import hsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_byte_i,
  input  logic       has_char_i,
  input  logic       last_char_i,
  output lex_t       next_o,
  output phase_e     phase_o
);

  phase_e phase_q, phase_d;
  lex_t   lex_q, lex_d;

  phase_e              eph;
  logic [67:0]         acc_wide;
  logic [FracW+3:0]    frac_wide;
  logic [3:0]          digit;

  // Multiply-accumulate of one decimal digit into the integer and fraction.
  always_comb begin
    digit     = char_byte_i[3:0];
    acc_wide  = ({4'b0, lex_q.acc} << 3) + ({4'b0, lex_q.acc} << 1) + 68'(digit);
    frac_wide = ({4'b0, lex_q.frac} << 3) + ({4'b0, lex_q.frac} << 1)
              + (FracW + 4)'(digit);
  end

  // One byte of the key advances the parse phase.
  always_comb begin
    phase_d = phase_q;
    lex_d   = lex_q;
    eph     = phase_q;
    if (has_char_i) begin
      if (eph == PH_LEAD) begin
        if (is_ws(char_byte_i)) begin
          eph = PH_DONE;
        end else begin
          phase_d = PH_INT;
          if (char_byte_i == ChMinus) begin
            lex_d.neg = 1'b1;
            eph       = PH_DONE;
          end else if (char_byte_i == ChPlus) begin
            eph = PH_DONE;
          end else begin
            eph = PH_INT;
          end
        end
      end
      if (eph == PH_INT) begin
        if (is_digit(char_byte_i)) begin
          if (!lex_q.ovf) begin
            if (acc_wide[67:64] != 4'b0) begin
              lex_d.ovf = 1'b1;
            end else begin
              lex_d.acc = acc_wide[63:0];
            end
          end
          eph = PH_DONE;
        end else if (char_byte_i == ChDot) begin
          phase_d = PH_FRAC;
          eph     = PH_DONE;
        end else begin
          eph = PH_SPACE;
        end
      end else if (eph == PH_FRAC) begin
        if (is_digit(char_byte_i)) begin
          if (lex_q.cnt < CntW'(FRAC_DIGITS)) begin
            lex_d.frac = frac_wide[FracW-1:0];
            lex_d.cnt  = lex_q.cnt + CntW'(1);
          end
          eph = PH_DONE;
        end else begin
          eph = PH_SPACE;
        end
      end
      if (eph == PH_SPACE) begin
        if (char_byte_i == ChSpace) begin
          phase_d = PH_SPACE;
        end else begin
          lex_d.shift = suffix_of(char_byte_i);
          phase_d     = PH_DONE;
        end
      end
    end
  end

  // Parse state; the last byte of a key returns it to the start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      lex_q   <= '0;
    end else if (take_i) begin
      if (last_char_i) begin
        phase_q <= PH_LEAD;
        lex_q   <= '0;
      end else begin
        phase_q <= phase_d;
        lex_q   <= lex_d;
      end
    end
  end

  assign next_o  = lex_d;
  assign phase_o = phase_q;

endmodule

`default_nettype wire

// File: src/hsp_scale.sv
`default_nettype none

module hsp_scale import hsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  lex_t        snap_i,
  input  logic        res_ready_i,
  output logic        busy_o,
  output logic        res_valid_o,
  output logic [63:0] res_value_o,
  output logic        res_sat_o
);

  scale_e state_q, state_d;

  lex_t              snap_q, snap_d;
  logic [FracW-1:0]  den_q, den_d;
  logic [FracW-1:0]  rem_q, rem_d;
  logic [63:0]       quo_q, quo_d;
  logic [ShiftW-1:0] step_q, step_d;
  logic              big_q, big_d;
  logic [63:0]       shl_q, shl_d;
  logic [63:0]       mag_q, mag_d;

  logic [FracW:0]    rem2;
  logic              ge;
  logic [63:0]       lim;
  logic              sat;

  // Restoring-division step: one quotient bit per cycle.
  always_comb begin
    rem2 = {rem_q, 1'b0};
    ge   = (rem2 >= {1'b0, den_q});
    lim  = snap_q.neg ? LimNeg : LimPos;
  end

  // Sequencer: divide, scale the integer, add, then hand out the result.
  always_comb begin
    state_d     = state_q;
    snap_d      = snap_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    big_d       = big_q;
    shl_d       = shl_q;
    mag_d       = mag_q;
    res_valid_o = 1'b0;
    case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          snap_d  = snap_i;
          den_d   = den_of(snap_i.cnt);
          rem_d   = snap_i.frac;
          quo_d   = '0;
          step_d  = '0;
          state_d = SC_DIV;
        end
      end
      SC_DIV: begin
        if (step_q == snap_q.shift) begin
          state_d = SC_SCALE;
        end else begin
          step_d = step_q + ShiftW'(1);
          quo_d  = {quo_q[62:0], ge};
          rem_d  = ge ? FracW'(rem2 - {1'b0, den_q}) : rem2[FracW-1:0];
        end
      end
      SC_SCALE: begin
        big_d   = snap_q.ovf || (snap_q.acc > (lim >> snap_q.shift));
        shl_d   = snap_q.acc << snap_q.shift;
        state_d = SC_SUM;
      end
      SC_SUM: begin
        mag_d   = shl_q + quo_q;
        state_d = SC_FINISH;
      end
      SC_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SC_IDLE;
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase
  end

  // Saturate or apply the sign to the finished magnitude.
  always_comb begin
    sat         = big_q || (mag_q > lim);
    res_sat_o   = sat;
    res_value_o = sat ? lim : (snap_q.neg ? (64'd0 - mag_q) : mag_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    big_q  <= big_d;
    shl_q  <= shl_d;
    mag_q  <= mag_d;
  end

  assign busy_o = (state_q != SC_IDLE);

endmodule

`default_nettype wire

// File: src/human_size_parser_core.sv
`default_nettype none

// Parses one text key such as "1.5K" or " -3 G" into a signed 64-bit value.
// Bytes are taken one per cycle while parsing. After the item that carries
// last_char, the input is not ready while the scaler works: a restoring
// divider over the fraction produces one quotient bit per cycle, one for each
// bit of the suffix shift (0, 10, 20, ... 60), and then finishes; after that
// the integer part is scaled, the fraction is added and the result is handed
// to the output register. The input stays blocked longer while that register
// is full and the sink holds off. A result waiting in the output register
// does not block parsing of the next key.
// Values beyond the signed 64-bit range saturate and set the saturated flag.

`include "human_size_parser_core_defines.svh"

module human_size_parser_core import hsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  hsp_in_if.sink   in_i,
  hsp_out_if.source out_o
);

  logic        take;
  logic        start;
  logic        busy;
  lex_t        lex_next;
  phase_e      lex_phase;
  logic        res_valid;
  logic        res_ready;
  logic [63:0] res_value;
  logic        res_sat;

  logic        out_valid_q;
  logic [63:0] out_value_q;
  logic        out_sat_q;

  // Input handshake: bytes are taken whenever the scaler is free.
  assign in_i.ready = !busy;
  assign take       = in_i.valid && in_i.ready;
  assign start      = take && in_i.last_char;

  hsp_lex u_lex (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_byte_i (in_i.char_byte),
    .has_char_i  (in_i.has_char),
    .last_char_i (in_i.last_char),
    .next_o      (lex_next),
    .phase_o     (lex_phase)
  );

  hsp_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .snap_i      (lex_next),
    .res_ready_i (res_ready),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_value_o (res_value),
    .res_sat_o   (res_sat)
  );

  // Output register holds one finished item until the sink takes it.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_value_q <= res_value;
      out_sat_q   <= res_sat;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.size_value = out_value_q;
  assign out_o.saturated  = out_sat_q;

  // The end of a key always starts the scaler.
  `HSP_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start, busy)
  // The lexer is back at its start while the scaler works.
  `HSP_ASSERT(a_lex_clear, clk_i, rst_ni, !busy || (lex_phase == PH_LEAD))
  // A blocked result stays offered until the output register frees up.
  `HSP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid && !res_ready, res_valid)
  // A saturated item carries one of the two limits.
  `HSP_ASSERT(a_sat_limit, clk_i, rst_ni,
    !(out_valid_q && out_sat_q) || (out_value_q == LimPos) || (out_value_q == LimNeg))

endmodule

`default_nettype wire
